@@ hdl/tcw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants for the text console character writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // operation codes
  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // control characters
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_RETURN    = 8'd13;

  // cell values
  localparam logic [15:0] RESET_CELL = 16'h0A00;
  localparam logic [15:0] TEXT_ATTR  = 16'h0200;
  localparam logic [15:0] BLANK_CELL = 16'h0000;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;   // latch a new transaction
    logic exec;   // execute the latched transaction
    logic clear;  // write one reset cell of the power-up sweep
    logic copy;   // move one cell up by a row
    logic fill;   // blank one cell of the bottom row
  } tcw_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic is_read;    // latched transaction is a cell read
    logic scroll;     // latched put needs a scroll
    logic copy_last;  // sweep pointer at the last cell to copy
    logic ptr_last;   // sweep pointer at the last cell
  } tcw_status_t;

endpackage
`default_nettype wire

@@ hdl/text_console_character_writer_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_character_writer_top
// Text console with a COLUMNS x ROWS cell memory and a cursor.
// ----------------------------------------------------------------------------
// Usage:
//   a transaction is taken at a clock edge with start high and busy low;
//   in_operation selects put (char from in_char_code) or cell read
//   (in_read_address). One result per transaction shows on out_* for one
//   cycle marked by out_valid, carrying the cursor after the transaction
//   and, on a read, the cell (0 for a put or an out-of-range address).
// Timing:
//   put or read: busy drops with the strobe, so a new transaction is
//   taken only once the last one has given its result.
//   a put that scrolls (newline or wrap on the last row) runs the cell
//   memory copy, one cell per cycle over its single write port, then
//   blanks the bottom row.
// Reset:
//   rst_n clears the cursor; busy then stays high for a clearing pass
//   that writes 0x0A00 to every cell.
// The receiver cannot stall; results must be taken on the strobe.
// ----------------------------------------------------------------------------
module text_console_character_writer_top #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_operation,
  input  wire logic [7:0]  in_char_code,
  input  wire logic [10:0] in_read_address,
  output logic             out_valid,
  output logic [6:0]       out_cursor_col,
  output logic [4:0]       out_cursor_row,
  output logic [15:0]      out_cell_data
);

  tcw_pkg::tcw_cmd_t    cmd;
  tcw_pkg::tcw_status_t status;

  // control sequencer
  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // memory, cursor and execution
  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_operation    (in_operation),
    .in_char_code    (in_char_code),
    .in_read_address (in_read_address),
    .status          (status),
    .out_cursor_col  (out_cursor_col),
    .out_cursor_row  (out_cursor_row),
    .out_cell_data   (out_cell_data)
  );

endmodule
`default_nettype wire

@@ hdl/tcw_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_ctrl
// Controller: sequences the power-up clear, transactions and scroll sweeps.
// ----------------------------------------------------------------------------
module tcw_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire tcw_pkg::tcw_status_t status,
  output tcw_pkg::tcw_cmd_t         cmd,
  output logic                      busy,
  output logic                      out_valid
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_COPY,
    S_FILL
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // next state, strobe and commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    cmd           = '0;
    case (state_r)
      S_INIT: begin
        cmd.clear = 1'b1;
        if (status.ptr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (!status.is_read && status.scroll) begin
          state_nxt = S_COPY;
        end else begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      S_COPY: begin
        cmd.copy = 1'b1;
        if (status.copy_last) state_nxt = S_FILL;
      end
      S_FILL: begin
        cmd.fill = 1'b1;
        if (status.ptr_last) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

@@ hdl/tcw_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_datapath
// Cell memory, cursor, sweep pointer and the put/read execution logic.
// ----------------------------------------------------------------------------
module tcw_datapath #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire tcw_pkg::tcw_cmd_t    cmd,
  input  wire logic                 in_operation,
  input  wire logic [7:0]           in_char_code,
  input  wire logic [10:0]          in_read_address,
  output tcw_pkg::tcw_status_t      status,
  output logic [6:0]                out_cursor_col,
  output logic [4:0]                out_cursor_row,
  output logic [15:0]               out_cell_data
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int COL_W = $clog2(COLUMNS);
  localparam int ROW_W = $clog2(ROWS);

  localparam logic [AW-1:0]    LAST_CELL = AW'(CELLS - 1);
  localparam logic [AW-1:0]    LAST_COPY = AW'(CELLS - COLUMNS - 1);
  localparam logic [AW-1:0]    ROW_STEP  = AW'(COLUMNS);
  localparam logic [COL_W-1:0] COL_LAST  = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0] ROW_LAST  = ROW_W'(ROWS - 1);

  // latched transaction
  logic        op_r;
  logic [7:0]  ch_r;
  logic [10:0] raddr_r;
  logic        addr_ok_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= in_operation;
      ch_r      <= in_char_code;
      raddr_r   <= in_read_address;
      addr_ok_r <= (32'(in_read_address) < 32'(CELLS));
    end
  end

  // cursor and sweep pointer
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] line_r, line_nxt;
  logic [AW-1:0]    ptr_r;

  // character decode
  logic is_nl, is_bs, is_cr, printable, last_row, last_col;
  assign is_nl     = (ch_r == tcw_pkg::CH_NEWLINE);
  assign is_bs     = (ch_r == tcw_pkg::CH_BACKSPACE);
  assign is_cr     = (ch_r == tcw_pkg::CH_RETURN);
  assign printable = !is_nl && !is_bs && !is_cr;
  assign last_row  = (line_r == ROW_LAST);
  assign last_col  = (col_r == COL_LAST);

  // cursor update for a put
  always_comb begin
    col_nxt  = col_r;
    line_nxt = line_r;
    if (is_nl || (printable && last_col)) begin
      col_nxt = '0;
      if (!last_row) line_nxt = line_r + 1'b1;
    end else if (is_bs) begin
      if (col_r == '0) begin
        if (line_r != '0) line_nxt = line_r - 1'b1;
      end else begin
        col_nxt = col_r - 1'b1;
      end
    end else if (is_cr) begin
      col_nxt = '0;
    end else begin
      col_nxt = col_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      line_r <= '0;
      ptr_r  <= '0;
    end else begin
      if (cmd.exec && op_r == tcw_pkg::OP_PUT) begin
        col_r  <= col_nxt;
        line_r <= line_nxt;
      end
      if (cmd.exec) begin
        ptr_r <= '0;
      end else if (cmd.clear || cmd.copy || cmd.fill) begin
        ptr_r <= ptr_r + 1'b1;
      end
    end
  end

  // cell address of the cursor
  logic [AW-1:0] put_addr;
  assign put_addr = AW'(AW'(line_r) * ROW_STEP) + AW'(col_r);

  // read address: row below during a scroll, else the requested cell
  logic [AW-1:0] rd_addr;
  assign rd_addr = cmd.copy ? (ptr_r + ROW_STEP) : AW'(raddr_r);

  // write command, registered and applied in the cycle after it is issued
  logic          wr_en_r;
  logic [AW-1:0] wr_addr_r;
  logic [15:0]   wr_data_r;
  logic          wr_from_rd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_en_r <= 1'b0;
    end else begin
      wr_en_r <= cmd.clear || cmd.copy || cmd.fill ||
                 (cmd.exec && op_r == tcw_pkg::OP_PUT && printable);
    end
  end

  always_ff @(posedge clk) begin
    wr_addr_r    <= cmd.exec ? put_addr : ptr_r;
    wr_from_rd_r <= cmd.copy;
    if (cmd.clear) begin
      wr_data_r <= tcw_pkg::RESET_CELL;
    end else if (cmd.fill) begin
      wr_data_r <= tcw_pkg::BLANK_CELL;
    end else begin
      wr_data_r <= tcw_pkg::TEXT_ATTR | {8'h00, ch_r};
    end
  end

  // cell memory: one write port, one registered read port
  logic [15:0] mem_r [CELLS];
  logic [15:0] rdata_r;

  always_ff @(posedge clk) begin
    if (wr_en_r) mem_r[wr_addr_r] <= wr_from_rd_r ? rdata_r : wr_data_r;
    rdata_r <= mem_r[rd_addr];
  end

  // status
  assign status.is_read   = (op_r == tcw_pkg::OP_READ);
  assign status.scroll    = last_row && (is_nl || (printable && last_col));
  assign status.copy_last = (ptr_r == LAST_COPY);
  assign status.ptr_last  = (ptr_r == LAST_CELL);

  // result fields
  assign out_cursor_col = 7'(col_r);
  assign out_cursor_row = 5'(line_r);
  assign out_cell_data  = (op_r == tcw_pkg::OP_READ && addr_ok_r) ? rdata_r : 16'h0000;

endmodule
`default_nettype wire

@@ hdl/tcw_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks of the console handshake, bound to the top level.
// ----------------------------------------------------------------------------
module tcw_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid
);

  // an accepted transaction makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after transaction");

  // the result strobe comes with the block ready again
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // a result ends a busy period
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without preceding work");

  // the strobe lasts one cycle
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

endmodule

bind text_console_character_writer_top tcw_checker u_tcw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);
`default_nettype wire

@@ test/tb_text_console_character_writer_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_console_character_writer_top
// Self-checking bench for the 80x25 text console writer. A short table of
// directed transactions covers the edges: reads at and past the last cell,
// backspace at column 0 and every control byte. Random puts and reads follow,
// with bursts of text that wrap lines and newlines that scroll at the bottom.
// A shadow copy of the cell store and cursor predicts every untyped result.
// ----------------------------------------------------------------------------
module tb_text_console_character_writer_top;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int RANDOM_PER_PHASE = 617;
  localparam int SCROLLS_PER_PHASE = 40;

  // package codes used throughout the bench
  localparam logic        OP_PUT       = tcw_pkg::OP_PUT;
  localparam logic        OP_READ      = tcw_pkg::OP_READ;
  localparam logic [7:0]  CH_NEWLINE   = tcw_pkg::CH_NEWLINE;
  localparam logic [7:0]  CH_BACKSPACE = tcw_pkg::CH_BACKSPACE;
  localparam logic [7:0]  CH_RETURN    = tcw_pkg::CH_RETURN;
  localparam logic [15:0] RESET_CELL   = tcw_pkg::RESET_CELL;
  localparam logic [15:0] TEXT_ATTR    = tcw_pkg::TEXT_ATTR;
  localparam logic [15:0] BLANK_CELL   = tcw_pkg::BLANK_CELL;

  typedef struct packed {
    logic [6:0]  col;
    logic [4:0]  row;
    logic [15:0] cell_data;
  } console_result_t;

  typedef struct packed {
    logic            op;
    logic [7:0]      ch;
    logic [10:0]     addr;
    logic            typed;
    console_result_t res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        in_operation = OP_PUT;
  logic [7:0]  in_char_code = 8'h00;
  logic [10:0] in_read_address = 11'd0;
  logic        busy;
  logic        out_valid;
  logic [6:0]  out_cursor_col;
  logic [4:0]  out_cursor_row;
  logic [15:0] out_cell_data;

  // shadow of the console state
  logic [15:0] shadow_cells [CELL_COUNT];
  int          shadow_col;
  int          shadow_row;

  console_result_t awaited_results [$];
  int              mismatches = 0;
  int              idle_pct = 0;

  stim_row_t directed_rows [25];

  text_console_character_writer_top #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_operation   (in_operation),
    .in_char_code   (in_char_code),
    .in_read_address(in_read_address),
    .out_valid      (out_valid),
    .out_cursor_col (out_cursor_col),
    .out_cursor_row (out_cursor_row),
    .out_cell_data  (out_cell_data)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

  // newline: column 0, next row or scroll the store up by one row
  function automatic void start_next_line();
    int i;
    shadow_col = 0;
    if (shadow_row + 1 >= ROWS) begin
      for (i = 0; i < CELL_COUNT - COLUMNS; i++) shadow_cells[i] = shadow_cells[i + COLUMNS];
      for (i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) shadow_cells[i] = BLANK_CELL;
    end else begin
      shadow_row++;
    end
  endfunction

  // update the shadow console with one transaction and return its result
  function automatic console_result_t apply_console_item(logic op, logic [7:0] ch,
                                                         logic [10:0] addr);
    console_result_t r;
    r.cell_data = BLANK_CELL;
    if (op == OP_PUT) begin
      if (ch == CH_NEWLINE) begin
        start_next_line();
      end else if (ch == CH_BACKSPACE) begin
        // at column 0 go up a row without erasing
        if (shadow_col == 0) begin
          if (shadow_row > 0) shadow_row--;
        end else begin
          shadow_col--;
        end
      end else if (ch == CH_RETURN) begin
        shadow_col = 0;
      end else begin
        shadow_cells[shadow_row * COLUMNS + shadow_col] = TEXT_ATTR | {8'h00, ch};
        shadow_col++;
        if (shadow_col >= COLUMNS) start_next_line();
      end
    end else if (addr < CELL_COUNT) begin
      r.cell_data = shadow_cells[addr];
    end
    r.col = shadow_col[6:0];
    r.row = shadow_row[4:0];
    return r;
  endfunction

  // drive one transaction, wait for acceptance, queue what it should return
  task automatic send_item(input logic op, input logic [7:0] ch, input logic [10:0] addr,
                           input logic typed, input console_result_t typed_res);
    console_result_t r;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start           <= 1'b1;
    in_operation    <= op;
    in_char_code    <= ch;
    in_read_address <= addr;
    do @(posedge clk); while (busy);
    r = apply_console_item(op, ch, addr);
    awaited_results.push_back(typed ? typed_res : r);
  endtask

  // result checker
  always @(posedge clk) begin : check_results
    console_result_t want;
    if (rst_n && out_valid) begin
      if (awaited_results.size() == 0) begin
        $error("unexpected result: col %0d row %0d cell %h",
               out_cursor_col, out_cursor_row, out_cell_data);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        if (out_cursor_col !== want.col) begin
          $error("cursor_col: expected %0d, actual %0d", want.col, out_cursor_col);
          mismatches++;
        end
        if (out_cursor_row !== want.row) begin
          $error("cursor_row: expected %0d, actual %0d", want.row, out_cursor_row);
          mismatches++;
        end
        if (out_cell_data !== want.cell_data) begin
          $error("cell_data: expected %h, actual %h", want.cell_data, out_cell_data);
          mismatches++;
        end
      end
    end
  end

  // stimulus
  initial begin
    int              phase;
    int              n;
    int              pick;
    int              burst_left;
    int              scrolls_left;
    logic            op;
    logic [7:0]      ch;
    logic [10:0]     addr;
    logic            is_text;
    console_result_t none;

    none = '0;
    burst_left = 0;
    foreach (shadow_cells[i]) shadow_cells[i] = RESET_CELL;
    shadow_col = 0;
    shadow_row = 0;

    // directed transactions; typed expectations where obvious
    directed_rows = '{
      '{OP_READ, 8'h00,        11'd0,    1'b1, '{7'd0, 5'd0, RESET_CELL}},
      '{OP_READ, 8'hFF,        11'd1999, 1'b1, '{7'd0, 5'd0, RESET_CELL}},
      '{OP_READ, 8'h00,        11'd2000, 1'b1, '{7'd0, 5'd0, BLANK_CELL}},
      '{OP_READ, 8'h55,        11'h7FF,  1'b1, '{7'd0, 5'd0, BLANK_CELL}},
      '{OP_PUT,  CH_BACKSPACE, 11'd0,    1'b1, '{7'd0, 5'd0, BLANK_CELL}},
      '{OP_PUT,  8'h41,        11'h7FF,  1'b1, '{7'd1, 5'd0, BLANK_CELL}},
      '{OP_PUT,  8'hFF,        11'd0,    1'b1, '{7'd2, 5'd0, BLANK_CELL}},
      '{OP_PUT,  8'h00,        11'd0,    1'b1, '{7'd3, 5'd0, BLANK_CELL}},
      '{OP_READ, 8'h00,        11'd0,    1'b1, '{7'd3, 5'd0, TEXT_ATTR | 16'h0041}},
      '{OP_READ, 8'h00,        11'd1,    1'b1, '{7'd3, 5'd0, TEXT_ATTR | 16'h00FF}},
      '{OP_READ, 8'h00,        11'd2,    1'b1, '{7'd3, 5'd0, TEXT_ATTR}},
      '{OP_PUT,  CH_BACKSPACE, 11'd0,    1'b1, '{7'd2, 5'd0, BLANK_CELL}},
      '{OP_PUT,  CH_RETURN,    11'd0,    1'b1, '{7'd0, 5'd0, BLANK_CELL}},
      '{OP_PUT,  CH_NEWLINE,   11'd0,    1'b1, '{7'd0, 5'd1, BLANK_CELL}},
      '{OP_PUT,  8'h7E,        11'd0,    1'b1, '{7'd1, 5'd1, BLANK_CELL}},
      '{OP_PUT,  CH_NEWLINE,   11'd0,    1'b1, '{7'd0, 5'd2, BLANK_CELL}},
      '{OP_PUT,  CH_BACKSPACE, 11'd0,    1'b1, '{7'd0, 5'd1, BLANK_CELL}},
      '{OP_READ, 8'h00,        11'd80,   1'b1, '{7'd0, 5'd1, TEXT_ATTR | 16'h007E}},
      '{OP_READ, 8'h00,        11'd3,    1'b1, '{7'd0, 5'd1, RESET_CELL}},
      '{OP_PUT,  8'h80,        11'h7FF,  1'b0, none},
      '{OP_READ, 8'hFF,        11'd81,   1'b0, none},
      '{OP_PUT,  CH_NEWLINE,   11'h555,  1'b0, none},
      '{OP_PUT,  8'h09,        11'h2AA,  1'b0, none},
      '{OP_READ, 8'h00,        11'd1920, 1'b0, none},
      '{OP_PUT,  8'h20,        11'd0,    1'b0, none}
    };

    // reset, then the block clears its store while busy
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    idle_pct = 25;
    foreach (directed_rows[i])
      send_item(directed_rows[i].op, directed_rows[i].ch, directed_rows[i].addr,
                directed_rows[i].typed, directed_rows[i].res);

    // random traffic: sender idles often, then a lot, then never
    for (phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 25 : (phase == 1) ? 83 : 0;
      scrolls_left = SCROLLS_PER_PHASE;
      for (n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (burst_left == 0 && $urandom_range(99) < 5) burst_left = $urandom_range(100, 20);
        op   = OP_PUT;
        ch   = 8'($urandom_range(255));
        addr = 11'($urandom_range(2047));
        if (burst_left > 0) begin
          // run of printable text, long enough to wrap lines
          ch = 8'($urandom_range(126, 32));
          burst_left--;
        end else begin
          pick = $urandom_range(99);
          if (pick < 25) begin
            op = OP_READ;
            if ($urandom_range(1)) addr = 11'(shadow_row * COLUMNS + $urandom_range(COLUMNS - 1));
          end else if (pick < 37) begin
            ch = CH_NEWLINE;
          end else if (pick < 44) begin
            ch = CH_BACKSPACE;
          end else if (pick < 49) begin
            ch = CH_RETURN;
          end
        end
        // scrolls are slow, so cap them per phase
        is_text = !(ch == CH_NEWLINE || ch == CH_BACKSPACE || ch == CH_RETURN);
        if (op == OP_PUT && shadow_row == ROWS - 1 &&
            (ch == CH_NEWLINE || (is_text && shadow_col == COLUMNS - 1))) begin
          if (scrolls_left == 0) ch = CH_RETURN;
          else scrolls_left--;
        end
        send_item(op, ch, addr, 1'b0, none);
      end
    end
    start <= 1'b0;

    // drain outstanding results, then a few quiet cycles
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
